// ===== src/mbi_pkg.sv =====
// mbi_pkg: shared types, constants and saturating fixed-point helpers
// for the escape-time iterator; no dependencies
package mbi_pkg;

   localparam int FRAC_BITS_DEF = 56;
   localparam int COUNT_BITS_DEF = 16;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] OUTCOME_ESCAPED = 2'd0;
   localparam logic [1:0] OUTCOME_INTERIOR = 2'd1;
   localparam logic [1:0] OUTCOME_CYCLE = 2'd2;
   localparam logic [1:0] OUTCOME_EXHAUSTED = 2'd3;

   localparam logic [0:0] CSR_MAX_ITER = 1'b0;
   localparam logic [0:0] CSR_ESCAPE_RADIUS = 1'b1;

   localparam logic [15:0] MAX_ITER_RESET = 16'd256;
   localparam logic [62:0] RADIUS_RESET = 63'h0400_0000_0000_0000;

   typedef struct packed {
      logic signed [63:0] c_re;
      logic signed [63:0] c_im;
   } req_type;

   typedef struct packed {
      logic [1:0] outcome;
      logic [15:0] steps_taken;
      logic [62:0] magnitude_sq;
   } rsp_type;

   // queue entry between front and back
   typedef struct packed {
      logic interior;
      logic signed [63:0] c_re;
      logic signed [63:0] c_im;
   } job_type;

   typedef enum logic [2:0] {
      FR_IDLE, FR_MUL, FR_WAIT, FR_DECIDE, FR_PUSH
   } front_state_type;

   typedef enum logic [2:0] {
      BK_IDLE, BK_TEST, BK_MUL, BK_WAIT, BK_UPDATE, BK_DONE
   } back_state_type;

   localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
      return s[63:0];
   endfunction

   function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
      return s[63:0];
   endfunction

   // saturating scale by 2^k, same as k saturating doublings
   function automatic logic signed [63:0] sat_shl(input logic signed [63:0] x,
                                                  input int k);
      logic signed [63:0] y;
      y = x <<< k;
      if ((y >>> k) != x) return x[63] ? S64_MIN : S64_MAX;
      return y;
   endfunction

   function automatic logic [63:0] mag64(input logic signed [63:0] x);
      return x[63] ? 64'(-x) : 64'(x);
   endfunction

   function automatic logic [62:0] capped_mag(input logic signed [63:0] x);
      logic [63:0] m;
      m = mag64(x);
      return m[63] ? {63{1'b1}} : m[62:0];
   endfunction

endpackage

// ===== src/mbi_mul.sv =====
// mbi_mul: multi-cycle saturating fixed-point multiplier, 32x32 partial products
// depends on mbi_pkg
module mbi_mul #(
   parameter int FRAC_BITS = mbi_pkg::FRAC_BITS_DEF
) (
   input logic clock,
   input logic reset,
   input logic start,
   input logic signed [63:0] a,
   input logic signed [63:0] b,
   output logic done,
   output logic signed [63:0] p
);
   import mbi_pkg::*;

   logic [2:0] phase_ff, phase_in;
   logic [63:0] ma_ff, mb_ff;
   logic neg_ff;
   logic [127:0] acc_ff, acc_in;
   logic [31:0] op_a, op_b;
   logic [63:0] part;
   logic [127:0] shifted;
   logic [127:0] mag;
   logic signed [63:0] p_ff;
   logic done_ff;

   // one partial product per cycle: ll, lh, hl, hh
   always_comb begin
      unique case (phase_ff[1:0])
         2'd0: begin op_a = ma_ff[31:0]; op_b = mb_ff[31:0]; end
         2'd1: begin op_a = ma_ff[31:0]; op_b = mb_ff[63:32]; end
         2'd2: begin op_a = ma_ff[63:32]; op_b = mb_ff[31:0]; end
         default: begin op_a = ma_ff[63:32]; op_b = mb_ff[63:32]; end
      endcase
      part = op_a * op_b;
      unique case (phase_ff[1:0])
         2'd0: shifted = {64'd0, part};
         2'd1, 2'd2: shifted = {32'd0, part, 32'd0};
         default: shifted = {part, 64'd0};
      endcase
      acc_in = acc_ff + shifted;
      phase_in = phase_ff;
      if (start) phase_in = 3'd4;
      else if (phase_ff[2]) phase_in = (phase_ff[1:0] == 2'd3) ? 3'd0 : phase_ff + 3'd1;
   end

   assign mag = acc_in >> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= 3'd0;
         done_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff <= phase_ff == 3'd7;
      end
      if (start) begin
         ma_ff <= mag64(a);
         mb_ff <= mag64(b);
         neg_ff <= a[63] ^ b[63];
         acc_ff <= '0;
      end else if (phase_ff[2]) begin
         acc_ff <= acc_in;
      end
      if (phase_ff == 3'd7) begin
         if (|mag[127:63]) begin
            if (neg_ff && mag[127:63] == 65'd1 && mag[62:0] == '0) p_ff <= S64_MIN;
            else p_ff <= neg_ff ? S64_MIN : S64_MAX;
         end else begin
            p_ff <= neg_ff ? -$signed({1'b0, mag[62:0]}) : $signed({1'b0, mag[62:0]});
         end
      end
   end

   assign done = done_ff;
   assign p = p_ff;
endmodule

// ===== src/mbi_front.sv =====
// mbi_front: accepts requests and runs the cardioid and bulb interior test
// depends on mbi_pkg, mbi_mul
module mbi_front #(
   parameter int FRAC_BITS = mbi_pkg::FRAC_BITS_DEF
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input mbi_pkg::req_type req_data,
   output logic push,
   output mbi_pkg::job_type push_job,
   input logic queue_full
);
   import mbi_pkg::*;

   localparam logic signed [63:0] FX_ONE = 64'sd1 <<< FRAC_BITS;
   localparam logic signed [63:0] FX_THREE = 64'sd3 <<< FRAC_BITS;
   localparam logic signed [63:0] FX_3_32 = 64'sd3 <<< (FRAC_BITS - 5);
   localparam logic signed [63:0] FX_1_16 = 64'sd1 <<< (FRAC_BITS - 4);

   front_state_type state_ff, state_in;
   logic [2:0] op_ff, op_in;
   logic signed [63:0] cr_ff, ci_ff, x2_ff, y2_ff, t_ff, t_in, u_ff;
   logic interior_ff, interior_in;
   logic mul_start, mul_done;
   logic signed [63:0] mul_a, mul_b, mul_p;

   mbi_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock, .reset, .start(mul_start), .a(mul_a), .b(mul_b),
      .done(mul_done), .p(mul_p)
   );

   // product sequence: x2, y2, zr*inner, zr*v, y2*(8y2-3), a*a
   always_comb begin
      unique case (op_ff)
         3'd0: begin mul_a = cr_ff; mul_b = cr_ff; end
         3'd1: begin mul_a = ci_ff; mul_b = ci_ff; end
         3'd2: begin mul_a = cr_ff; mul_b = t_ff; end
         3'd3: begin mul_a = cr_ff; mul_b = t_ff; end
         3'd4: begin mul_a = y2_ff; mul_b = t_ff; end
         default: begin mul_a = t_ff; mul_b = t_ff; end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FR_IDLE: if (req_valid) state_in = FR_MUL;
         FR_MUL: state_in = FR_WAIT;
         FR_WAIT: if (mul_done) state_in = FR_DECIDE;
         FR_DECIDE: state_in = (interior_in || op_ff == 3'd5) ? FR_PUSH : FR_MUL;
         FR_PUSH: if (!queue_full) state_in = FR_IDLE;
         default: state_in = FR_IDLE;
      endcase
   end

   always_comb begin
      req_stall = state_ff != FR_IDLE;
      mul_start = state_ff == FR_MUL;
      push = state_ff == FR_PUSH && !queue_full;
      push_job = '{interior: interior_ff, c_re: cr_ff, c_im: ci_ff};
      op_in = op_ff + 3'd1;
      t_in = t_ff;
      interior_in = 1'b0;
      unique case (op_ff)
         3'd0: t_in = t_ff;
         3'd1: t_in = sat_add(sat_shl(x2_ff, 3), sat_sub(sat_shl(mul_p, 4), FX_THREE));
         3'd2: t_in = sat_add(FX_ONE, mul_p);
         3'd3: t_in = sat_sub(sat_shl(y2_ff, 3), FX_THREE);
         3'd4: begin
            interior_in = sat_add(u_ff, mul_p) < FX_3_32;
            t_in = sat_add(cr_ff, FX_ONE);
         end
         default: interior_in = sat_add(mul_p, y2_ff) < FX_1_16;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (state_ff == FR_IDLE) begin
         cr_ff <= req_data.c_re;
         ci_ff <= req_data.c_im;
         op_ff <= 3'd0;
         interior_ff <= 1'b0;
      end else if (state_ff == FR_DECIDE) begin
         op_ff <= op_in;
         t_ff <= t_in;
         interior_ff <= interior_in;
         if (op_ff == 3'd0) x2_ff <= mul_p;
         if (op_ff == 3'd1) y2_ff <= mul_p;
         if (op_ff == 3'd3) u_ff <= mul_p;
      end
   end

   // 8*y2 - 3 term needs y2 stored; recompute from register on op 3
   // (t_in above uses y2_ff which is already written by then)
endmodule

// ===== src/mbi_queue.sv =====
// mbi_queue: small job queue between front and back
// depends on mbi_pkg
module mbi_queue (
   input logic clock,
   input logic reset,
   input logic push,
   input mbi_pkg::job_type push_job,
   output logic full,
   input logic pop,
   output logic empty,
   output mbi_pkg::job_type head
);
   import mbi_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   job_type slot_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ff, rd_ff;
   logic [PW:0] count_ff;

   assign full = count_ff == (PW+1)'(QUEUE_DEPTH);
   assign empty = count_ff == '0;
   assign head = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         count_ff <= count_ff + (PW+1)'(push) - (PW+1)'(pop);
      end
      if (push) slot_ff[wr_ff] <= push_job;
   end
endmodule

// ===== src/mbi_back.sv =====
// mbi_back: escape-time loop with snapshot cycle check and result register
// depends on mbi_pkg, mbi_mul
module mbi_back #(
   parameter int FRAC_BITS = mbi_pkg::FRAC_BITS_DEF,
   parameter int COUNT_BITS = mbi_pkg::COUNT_BITS_DEF
) (
   input logic clock,
   input logic reset,
   input logic empty,
   input mbi_pkg::job_type head,
   output logic pop,
   input logic [15:0] max_iter,
   input logic [62:0] escape_radius,
   output logic rsp_valid,
   input logic rsp_stall,
   output mbi_pkg::rsp_type rsp_data
);
   import mbi_pkg::*;

   back_state_type state_ff, state_in;
   logic [COUNT_BITS-1:0] count_ff, budget_ff, cnext;
   logic signed [63:0] zr_ff, zi_ff, cr_ff, ci_ff, sr_ff, si_ff;
   logic signed [63:0] p0_ff, p1_ff, new_r, new_i;
   logic [1:0] op_ff;
   logic esc_ff;
   logic mul_start, mul_done;
   logic signed [63:0] mul_a, mul_b, mul_p;
   logic [63:0] msum;
   logic signed [63:0] mag_sum;
   logic escape_hit, match;

   mbi_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock, .reset, .start(mul_start), .a(mul_a), .b(mul_b),
      .done(mul_done), .p(mul_p)
   );

   // step products: ci*cr, (cr-ci)(cr+ci); escape products: cr*cr, ci*ci
   always_comb begin
      unique case ({esc_ff, op_ff[0]})
         2'b00: begin mul_a = ci_ff; mul_b = cr_ff; end
         2'b01: begin mul_a = sat_sub(cr_ff, ci_ff); mul_b = sat_add(cr_ff, ci_ff); end
         2'b10: begin mul_a = cr_ff; mul_b = cr_ff; end
         default: begin mul_a = ci_ff; mul_b = ci_ff; end
      endcase
   end

   assign msum = {1'b0, capped_mag(cr_ff)} + {1'b0, capped_mag(ci_ff)};
   assign escape_hit = msum >= {1'b0, escape_radius};
   assign cnext = count_ff - 1'b1;
   assign new_i = sat_add(sat_add(p0_ff, p0_ff), zi_ff);
   assign new_r = sat_add(p1_ff, zr_ff);
   assign match = (cnext & (cnext - 1'b1)) != '0 && new_r == sr_ff && new_i == si_ff;
   assign mag_sum = sat_add(p0_ff, p1_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: if (!empty) state_in = head.interior ? BK_DONE : BK_TEST;
         BK_TEST: state_in = (count_ff == '0) ? BK_DONE : BK_MUL;
         BK_MUL: state_in = BK_WAIT;
         BK_WAIT: if (mul_done) state_in = (op_ff[0]) ? (esc_ff ? BK_DONE : BK_UPDATE)
                                                       : BK_MUL;
         BK_UPDATE: state_in = match ? BK_DONE : BK_TEST;
         BK_DONE: if (!rsp_valid || !rsp_stall) state_in = BK_IDLE;
         default: state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop = state_ff == BK_IDLE && !empty;
      mul_start = state_ff == BK_MUL;
   end

   logic [1:0] outcome_ff;
   logic rsp_valid_ff;
   rsp_type rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         if (state_ff == BK_DONE && (!rsp_valid_ff || !rsp_stall)) rsp_valid_ff <= 1'b1;
      end
      unique case (state_ff)
         BK_IDLE: begin
            zr_ff <= head.c_re;
            zi_ff <= head.c_im;
            cr_ff <= head.c_re;
            ci_ff <= head.c_im;
            sr_ff <= head.c_re;
            si_ff <= head.c_im;
            budget_ff <= COUNT_BITS'(max_iter);
            count_ff <= COUNT_BITS'(max_iter);
            outcome_ff <= head.interior ? OUTCOME_INTERIOR : OUTCOME_EXHAUSTED;
            esc_ff <= 1'b0;
            op_ff <= 2'd0;
         end
         BK_TEST: begin
            op_ff <= 2'd0;
            if (count_ff != '0 && escape_hit) esc_ff <= 1'b1;
         end
         BK_WAIT: if (mul_done) begin
            op_ff <= op_ff + 2'd1;
            if (op_ff[0]) p1_ff <= mul_p;
            else p0_ff <= mul_p;
         end
         BK_UPDATE: begin
            count_ff <= cnext;
            cr_ff <= new_r;
            ci_ff <= new_i;
            if ((cnext & (cnext - 1'b1)) == '0) begin
               sr_ff <= new_r;
               si_ff <= new_i;
            end
            if (match) outcome_ff <= OUTCOME_CYCLE;
         end
         default: ;
      endcase
      if (state_ff == BK_DONE && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_ff.outcome <= esc_ff ? OUTCOME_ESCAPED : outcome_ff;
         rsp_ff.steps_taken <= 16'(outcome_ff == OUTCOME_INTERIOR ? '0
                                   : budget_ff - count_ff);
         rsp_ff.magnitude_sq <= esc_ff ? mag_sum[62:0] : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
endmodule

// ===== src/mandelbrot_escape_iterator.sv =====
// mandelbrot_escape_iterator: top level, front precheck, job queue, iteration back end
// depends on mbi_pkg, mbi_front, mbi_queue, mbi_back
//
//   port group  direction  handshake        payload
//   req_        in         valid / stall    c_re, c_im (Q7.56)
//   rsp_        out        valid / stall    outcome, steps_taken, magnitude_sq
//   csr_        in         write enable     max_iter, escape_radius
//
// one shared multiplier per part, one product at a time: the front runs the
// interior test for each request, the back runs the iterations and then the
// escape products and the result, so the cost of a point grows with
// steps_taken and is set by the back multiplier
// synchronous active-high reset clears control; the queue holds two jobs so the
// front keeps accepting while the back iterates, until the queue is full; rsp_stall
// holds the result register and the back end, and the front once the queue is full
module mandelbrot_escape_iterator #(
   parameter int FRAC_BITS = mbi_pkg::FRAC_BITS_DEF,
   parameter int COUNT_BITS = mbi_pkg::COUNT_BITS_DEF
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input mbi_pkg::req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output mbi_pkg::rsp_type rsp_data,
   input logic csr_write,
   input logic [0:0] csr_index,
   input logic [62:0] csr_data
);
   import mbi_pkg::*;

   logic [15:0] max_iter_ff;
   logic [62:0] radius_ff;
   logic push, full, pop, empty;
   job_type push_job, head;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff <= MAX_ITER_RESET;
         radius_ff <= RADIUS_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_MAX_ITER: max_iter_ff <= csr_data[15:0];
            default: radius_ff <= csr_data;
         endcase
      end
   end

   mbi_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_data,
      .push, .push_job, .queue_full(full)
   );

   mbi_queue u_queue (
      .clock, .reset, .push, .push_job, .full, .pop, .empty, .head
   );

   mbi_back #(.FRAC_BITS(FRAC_BITS), .COUNT_BITS(COUNT_BITS)) u_back (
      .clock, .reset, .empty, .head, .pop,
      .max_iter(max_iter_ff), .escape_radius(radius_ff),
      .rsp_valid, .rsp_stall, .rsp_data
   );
endmodule

// ===== tb/mandelbrot_escape_iterator_tb.sv =====
// mandelbrot_escape_iterator_tb: self-checking bench for the escape-time iterator
// depends on mbi_pkg and mandelbrot_escape_iterator; predicts each result in a
// scoreboard class and drives random requests, stalls and register settings
module mandelbrot_escape_iterator_tb;
   import mbi_pkg::*;

   localparam int IDLE_LIMIT = 50000;   // cycles with no handshake before giving up
   localparam int SETTLE_CYCLES = 100;  // quiet time after the last result

   // Q7.56 constants used by the predictor and the stimulus
   localparam logic signed [63:0] Q_ONE = 64'sd1 <<< 56;
   localparam logic signed [63:0] Q_THREE = 64'sd3 <<< 56;
   localparam logic signed [63:0] Q_3_32 = 64'sd3 <<< 51;
   localparam logic signed [63:0] Q_1_16 = 64'sd1 <<< 52;
   localparam logic signed [63:0] Q_POS = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] Q_NEG = 64'sh8000_0000_0000_0000;
   localparam logic [62:0] RADIUS_TOP = {63{1'b1}};

   // predicts escape results and checks what the block returns
   class escape_scoreboard;
      logic [15:0] budget_reg = MAX_ITER_RESET;
      logic [62:0] radius_reg = RADIUS_RESET;
      rsp_type expected_q[$];
      int errors = 0;

      function logic signed [63:0] qadd(logic signed [63:0] a, logic signed [63:0] b);
         logic signed [64:0] s;
         s = {a[63], a} + {b[63], b};
         if (s[64] != s[63]) return s[64] ? Q_NEG : Q_POS;
         return s[63:0];
      endfunction

      function logic signed [63:0] qsub(logic signed [63:0] a, logic signed [63:0] b);
         logic signed [64:0] s;
         s = {a[63], a} - {b[63], b};
         if (s[64] != s[63]) return s[64] ? Q_NEG : Q_POS;
         return s[63:0];
      endfunction

      function logic signed [63:0] qdouble(logic signed [63:0] x, int times);
         for (int k = 0; k < times; k++) x = qadd(x, x);
         return x;
      endfunction

      // product of magnitudes truncated, then signed and saturated
      function logic signed [63:0] qmul(logic signed [63:0] a, logic signed [63:0] b);
         logic [63:0] ma, mb, m;
         logic [127:0] prod;
         logic neg;
         neg = a[63] ^ b[63];
         ma = a[63] ? 64'(-a) : 64'(a);
         mb = b[63] ? 64'(-b) : 64'(b);
         prod = {64'b0, ma} * {64'b0, mb};
         if (prod[127:120] != 0) return neg ? Q_NEG : Q_POS;
         m = prod[119:56];
         if (neg) return m[63] ? Q_NEG : -$signed(m);
         return m[63] ? Q_POS : $signed(m);
      endfunction

      function logic [62:0] clipped_abs(logic signed [63:0] x);
         logic [63:0] m;
         m = x[63] ? 64'(-x) : 64'(x);
         return m[63] ? RADIUS_TOP : m[62:0];
      endfunction

      // main cardioid polynomial and period-2 bulb disc
      function bit in_main_bulbs(logic signed [63:0] zr, logic signed [63:0] zi);
         logic signed [63:0] x2, y2, inner, v, p, a;
         x2 = qmul(zr, zr);
         y2 = qmul(zi, zi);
         inner = qadd(qdouble(x2, 3), qsub(qdouble(y2, 4), Q_THREE));
         v = qadd(Q_ONE, qmul(zr, inner));
         p = qadd(qmul(zr, v), qmul(y2, qsub(qdouble(y2, 3), Q_THREE)));
         a = qadd(zr, Q_ONE);
         if (p < Q_3_32) return 1;
         return qadd(qmul(a, a), y2) < Q_1_16;
      endfunction

      function rsp_type escape_of(req_type r);
         logic signed [63:0] cr, ci, sr, si, twice, mag_sq;
         logic [63:0] manh;
         logic [15:0] count;
         rsp_type res;
         res = '0;
         res.outcome = OUTCOME_EXHAUSTED;
         if (in_main_bulbs(r.c_re, r.c_im)) begin
            res.outcome = OUTCOME_INTERIOR;
            return res;
         end
         cr = r.c_re;
         ci = r.c_im;
         sr = cr;
         si = ci;
         count = budget_reg;
         while (count != 0) begin
            // escape test happens before each step
            manh = {1'b0, clipped_abs(cr)} + {1'b0, clipped_abs(ci)};
            if (manh >= {1'b0, radius_reg}) begin
               mag_sq = qadd(qmul(cr, cr), qmul(ci, ci));
               res.magnitude_sq = mag_sq[62:0];
               res.outcome = OUTCOME_ESCAPED;
               break;
            end
            count--;
            twice = qdouble(qmul(ci, cr), 1);
            cr = qadd(qmul(qsub(cr, ci), qadd(cr, ci)), r.c_re);
            ci = qadd(twice, r.c_im);
            // snapshot retaken at zero or a power of two, compared otherwise
            if ((count & (count - 16'd1)) != 0) begin
               if (cr == sr && ci == si) begin
                  res.outcome = OUTCOME_CYCLE;
                  break;
               end
            end else begin
               sr = cr;
               si = ci;
            end
         end
         res.steps_taken = budget_reg - count;
         return res;
      endfunction

      function void note_request(req_type r);
         expected_q.push_back(escape_of(r));
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got.outcome !== want.outcome) begin
            $display("%0t: outcome expected %0d got %0d", $time, want.outcome, got.outcome);
            errors++;
         end
         if (got.steps_taken !== want.steps_taken) begin
            $display("%0t: steps_taken expected %0d got %0d", $time,
                     want.steps_taken, got.steps_taken);
            errors++;
         end
         if (got.magnitude_sq !== want.magnitude_sq) begin
            $display("%0t: magnitude_sq expected %h got %h", $time,
                     want.magnitude_sq, got.magnitude_sq);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_type req_data;
   logic rsp_valid;
   logic rsp_stall;
   rsp_type rsp_data;
   logic csr_write;
   logic [0:0] csr_index;
   logic [62:0] csr_data;

   escape_scoreboard sb = new;
   int idle_cycles = 0;
   int draws = 0;
   bit busy_stretch = 0;

   mandelbrot_escape_iterator DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // wait per handshake, with stretches of back-to-back traffic
   function automatic int pick_wait();
      draws++;
      if (draws % 40 == 0) busy_stretch = ($urandom_range(0, 2) == 0);
      return busy_stretch ? 0 : $urandom_range(0, 12);
   endfunction

   function automatic logic signed [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // mix of full-range bits, extremes, points near the set, coarse grid points
   function automatic logic signed [63:0] pick_coord();
      logic signed [63:0] r;
      r = rand64();
      case ($urandom_range(0, 9))
         0, 1: return r;
         2: begin
            case ($urandom_range(0, 5))
               0: return Q_POS;
               1: return Q_NEG;
               2: return 0;
               3: return -Q_ONE;
               4: return 64'sd1;
               default: return -64'sd1;
            endcase
         end
         3, 4, 5, 6: return r >>> 5;               // within +-4.0
         default: return (r >>> 6) & ~64'sh0000_FFFF_FFFF_FFFF;  // exact grid, +-2.0
      endcase
   endfunction

   // points that finish in a handful of steps, for the largest budget
   function automatic req_type quick_point();
      req_type r;
      case ($urandom_range(0, 2))
         0: begin
            r.c_re = (Q_ONE <<< 2) + (rand64() >>> 8);
            if ($urandom_range(0, 1)) r.c_re = -r.c_re;
            r.c_im = rand64();
         end
         1: begin
            r.c_re = rand64() >>> 12;              // near zero, inside the cardioid
            r.c_im = rand64() >>> 12;
         end
         default: begin
            r.c_re = Q_ONE + (rand64() >>> 9);     // real axis near 1 escapes fast
            r.c_im = 0;
         end
      endcase
      return r;
   endfunction

   task automatic send_request(req_type r);
      int gap;
      gap = pick_wait();
      repeat (gap) begin
         @(negedge clock);
         req_valid = 0;
      end
      @(negedge clock);
      req_valid = 1;
      req_data = r;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
   endtask

   task automatic write_register(logic [0:0] index, logic [62:0] value);
      @(negedge clock);
      req_valid = 0;
      csr_write = 1;
      csr_index = index;
      csr_data = value;
      @(negedge clock);
      csr_write = 0;
      if (index == CSR_MAX_ITER) sb.budget_reg = value[15:0];
      else sb.radius_reg = value;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(logic [62:0] budget, logic [62:0] radius, int count, bit quick);
      drain();
      write_register(CSR_MAX_ITER, budget);
      write_register(CSR_ESCAPE_RADIUS, radius);
      for (int n = 0; n < count; n++) begin
         req_type r;
         if (quick) r = quick_point();
         else begin
            r.c_re = pick_coord();
            r.c_im = pick_coord();
         end
         send_request(r);
      end
   endtask

   // result side: random stall before each result, check on acceptance
   initial begin
      int w;
      rsp_stall = 0;
      forever begin
         w = pick_wait();
         if (w > 0) begin
            @(negedge clock);
            rsp_stall = 1;
            repeat (w - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_stall = 0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
         sb.check_result(rsp_data);
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("mandelbrot_escape_iterator_tb: FAIL");
         $finish;
      end
   end

   initial begin
      req_type d;
      reset = 1;
      req_valid = 0;
      req_data = '0;
      csr_write = 0;
      csr_index = CSR_MAX_ITER;
      csr_data = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed points at the reset settings
      d = '{c_re: 0, c_im: 0};                       send_request(d);  // cardioid center
      d = '{c_re: -Q_ONE, c_im: 0};                  send_request(d);  // period-2 bulb
      d = '{c_re: -(Q_ONE <<< 1), c_im: 0};          send_request(d);  // lands on fixed point
      d = '{c_re: 0, c_im: Q_ONE};                   send_request(d);  // preperiodic, cycles
      d = '{c_re: Q_ONE, c_im: 0};                   send_request(d);  // escapes in steps
      d = '{c_re: Q_ONE <<< 2, c_im: 0};             send_request(d);  // on the radius
      d = '{c_re: (Q_ONE <<< 2) - 1, c_im: 0};       send_request(d);  // just inside
      d = '{c_re: Q_POS, c_im: Q_POS};               send_request(d);
      d = '{c_re: Q_NEG, c_im: Q_NEG};               send_request(d);
      d = '{c_re: Q_NEG, c_im: Q_POS};               send_request(d);
      d = '{c_re: Q_ONE >>> 2, c_im: 0};             send_request(d);  // cardioid cusp
      d = '{c_re: -(Q_ONE >>> 2) * 3, c_im: 0};      send_request(d);  // bulb junction
      d = '{c_re: Q_ONE >>> 1, c_im: 0};             send_request(d);
      d = '{c_re: 0, c_im: Q_ONE <<< 1};             send_request(d);
      d = '{c_re: -64'sd1, c_im: 64'sd1};            send_request(d);
      d = '{c_re: -(Q_ONE >>> 1) * 3, c_im: 0};      send_request(d);

      run_phase(63'(MAX_ITER_RESET), RADIUS_RESET, 60, 0);
      run_phase(63'd1, 63'd0, 150, 0);                 // every point outside the bulbs escapes at once
      run_phase(63'd1, RADIUS_TOP, 150, 0);            // escapes at once or exhausts after one step
      run_phase(63'h7FFF_FFFF_FFFF_0000, RADIUS_RESET, 100, 0);  // budget masks to zero
      run_phase(63'h10_0010, (63'd1 << 57) + 63'({$urandom, $urandom} >> 7), 650, 0);
      run_phase(63'd32, RADIUS_TOP, 300, 0);
      run_phase(63'd8, 63'd1 << 57, 300, 0);
      run_phase(63'd65535, RADIUS_RESET, 20, 1);       // largest budget, quick points only

      @(negedge clock);
      req_valid = 0;
      drain();
      if (sb.errors == 0) begin
         $display("mandelbrot_escape_iterator_tb: PASS");
      end else begin
         $display("mandelbrot_escape_iterator_tb: FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/mbi_pkg.sv
src/mbi_mul.sv
src/mbi_front.sv
src/mbi_queue.sv
src/mbi_back.sv
src/mandelbrot_escape_iterator.sv
tb/mandelbrot_escape_iterator_tb.sv
